// ===== sv/wsp_pkg.sv =====
// Shared types and constants for the wheel speed PI controller.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package wsp_pkg;

    localparam logic [1:0] CFG_TARGET = 2'd0;
    localparam logic [1:0] CFG_PROP   = 2'd1;
    localparam logic [1:0] CFG_INTEG  = 2'd2;

    localparam logic [7:0]  TARGET_RESET = 8'd150;
    localparam logic [11:0] PROP_RESET   = 12'd51;
    localparam logic [11:0] INTEG_RESET  = 12'd13;

    localparam logic [7:0]  SPIKE_LIMIT = 8'd30;
    localparam logic [7:0]  DUTY_MAX    = 8'd255;
    localparam logic [7:0]  OLD_WEIGHT  = 8'd179;
    localparam logic [7:0]  NEW_WEIGHT  = 8'd77;
    localparam logic [7:0]  EST_ROUND   = 8'd128;

    typedef struct packed {
        logic signed [17:0] err;
        logic signed [18:0] diff;
        logic signed [8:0]  steer;
        logic [15:0]        speed;
    } t_est_word;

endpackage

// ===== sv/wsp_spike_filter.sv =====
// Three-sample spike filter for one wheel, with its two-deep count history.
// Depends on wsp_pkg.
`timescale 1ns / 1ps

module wsp_spike_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_upd,
    input  logic [7:0] i_count,
    output logic [7:0] o_pick
);

    logic [7:0] r_hist0;
    logic [7:0] r_hist1;
    logic [7:0] w_diff;

    always_comb begin
        if (i_count > r_hist0) begin
            w_diff = i_count - r_hist0;
        end else begin
            w_diff = r_hist0 - i_count;
        end
        if (w_diff > wsp_pkg::SPIKE_LIMIT) begin
            o_pick = (i_count > r_hist0) ? i_count : r_hist0;
        end else begin
            o_pick = r_hist1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist0 <= '0;
            r_hist1 <= '0;
        end else if (i_upd) begin
            r_hist0 <= i_count;
            r_hist1 <= r_hist0;
        end
    end

    a_hist_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd |=> (r_hist1 == $past(r_hist0)) && (r_hist0 == $past(i_count)))
        else $error("spike filter history did not shift");

endmodule

// ===== sv/wsp_estimator.sv =====
// Speed low-pass filter and error stage; holds speed estimate and last error.
// Depends on wsp_pkg.
`timescale 1ns / 1ps

module wsp_estimator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [7:0]          i_left_pick,
    input  logic [7:0]          i_right_pick,
    input  logic signed [8:0]   i_steer,
    input  logic [7:0]          i_target,
    output logic                o_valid,
    output wsp_pkg::t_est_word  o_word
);

    logic               w_upd;
    logic [15:0]        w_mean;
    logic [23:0]        w_acc;
    logic [15:0]        n_est;
    logic signed [17:0] n_err;
    logic signed [18:0] w_diff;

    logic               r_valid;
    logic [15:0]        r_est;
    logic signed [17:0] r_prev_err;
    wsp_pkg::t_est_word r_word;

    assign w_upd  = i_en && i_valid;
    assign w_mean = {9'(i_left_pick) + 9'(i_right_pick), 7'd0};
    assign w_acc  = 24'(wsp_pkg::OLD_WEIGHT) * 24'(r_est)
                  + 24'(wsp_pkg::NEW_WEIGHT) * 24'(w_mean)
                  + 24'(wsp_pkg::EST_ROUND);
    assign n_est  = w_acc[23:8];
    assign n_err  = $signed({2'b00, i_target, 8'd0}) - $signed({2'b00, n_est});
    assign w_diff = 19'(n_err) - 19'(r_prev_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_est      <= '0;
            r_prev_err <= '0;
        end else if (i_en) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_est      <= n_est;
                r_prev_err <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            r_word.err   <= n_err;
            r_word.diff  <= w_diff;
            r_word.steer <= i_steer;
            r_word.speed <= n_est;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

    a_err_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_upd |=> (r_prev_err == r_word.err) && (r_est == r_word.speed))
        else $error("stored error or estimate differs from forwarded word");

    a_est_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_upd |=> $stable(r_est) && $stable(r_prev_err))
        else $error("estimator state changed without an item");

endmodule

// ===== sv/wsp_duty_stage.sv =====
// Gain products, feedforward sum, steering and duty saturation; output register.
// Depends on wsp_pkg.
`timescale 1ns / 1ps

module wsp_duty_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  wsp_pkg::t_est_word  i_word,
    input  logic [7:0]          i_target,
    input  logic [11:0]         i_kp,
    input  logic [11:0]         i_ki,
    output logic                o_valid,
    output logic [7:0]          o_left,
    output logic [7:0]          o_right,
    output logic [15:0]         o_speed
);

    logic signed [31:0] n_p;
    logic signed [30:0] n_i;
    logic signed [35:0] w_base;
    logic signed [35:0] w_steer_q;
    logic signed [35:0] w_u_left;
    logic signed [35:0] w_u_right;
    logic [7:0]         n_left;
    logic [7:0]         n_right;

    logic               r_s2_valid;
    logic signed [31:0] r_p;
    logic signed [30:0] r_i;
    logic signed [8:0]  r_steer;
    logic [15:0]        r_speed;

    logic               r_out_valid;
    logic [7:0]         r_left;
    logic [7:0]         r_right;
    logic [15:0]        r_speed_out;

    function automatic logic [7:0] sat_duty(input logic signed [35:0] u);
        logic [7:0] d;
        if (u[35]) begin
            d = '0;
        end else if (u[34:16] > 19'(wsp_pkg::DUTY_MAX)) begin
            d = wsp_pkg::DUTY_MAX;
        end else begin
            d = u[23:16];
        end
        return d;
    endfunction

    assign n_p = 32'(i_word.diff) * 32'($signed({1'b0, i_kp}));
    assign n_i = 31'(i_word.err) * 31'($signed({1'b0, i_ki}));

    assign w_base    = 36'($signed({1'b0, i_target, 16'd0})) + 36'(r_p) + 36'(r_i);
    assign w_steer_q = 36'($signed({r_steer, 16'd0}));
    assign w_u_left  = w_base - w_steer_q;
    assign w_u_right = w_base + w_steer_q;
    assign n_left    = sat_duty(w_u_left);
    assign n_right   = sat_duty(w_u_right);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid  <= i_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_p     <= n_p;
            r_i     <= n_i;
            r_steer <= i_word.steer;
            r_speed <= i_word.speed;
        end
        if (i_en && r_s2_valid) begin
            r_left      <= n_left;
            r_right     <= n_right;
            r_speed_out <= r_speed;
        end
    end

    assign o_valid = r_out_valid;
    assign o_left  = r_left;
    assign o_right = r_right;
    assign o_speed = r_speed_out;

    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_s2_valid) |=> r_out_valid && (r_speed_out == $past(r_speed)))
        else $error("product stage word lost on its way to the output");

endmodule

// ===== sv/wheel_speed_pi_controller_unit.sv =====
// Top level of the wheel speed PI controller: config registers, input stage
// and the filter / estimator / duty pipeline. Depends on wsp_pkg and all wsp_ modules.
//
//  channel   dir  payload (low bit up)                          handshake
//  s_axis    in   left_count 8, right_count 8, steer_offset 9   tvalid/tready
//  m_axis    out  left_duty 8, right_duty 8, filtered_speed 16  tvalid/tready
//  cfg       in   index 2, wdata 12                             i_cfg_we
//
// One word per cycle unless m_axis stalls; a word passes the input, estimator,
// product and output registers. Estimate / last error feedback closes in the estimator.
// The whole pipeline advances together; it stalls only while a result waits on m_axis.
// Synchronous active-low reset clears valids, history, estimate and error; config
// registers return to 150 / 51 / 13.
`timescale 1ns / 1ps

module wheel_speed_pi_controller_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // left_count, right_count, steer_offset, zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // left_duty, right_duty, filtered_speed
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_wdata
);

    logic [7:0]  r_target;
    logic [11:0] r_kp;
    logic [11:0] r_ki;

    logic              w_en;
    logic              r_s0_valid;
    logic [7:0]        r_s0_left;
    logic [7:0]        r_s0_right;
    logic signed [8:0] r_s0_steer;

    logic [7:0]         w_left_pick;
    logic [7:0]         w_right_pick;
    logic               w_s1_valid;
    wsp_pkg::t_est_word w_s1_word;
    logic               w_out_valid;
    logic [7:0]         w_left_duty;
    logic [7:0]         w_right_duty;
    logic [15:0]        w_speed;

    assign w_en          = !w_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= wsp_pkg::TARGET_RESET;
            r_kp     <= wsp_pkg::PROP_RESET;
            r_ki     <= wsp_pkg::INTEG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wsp_pkg::CFG_TARGET: r_target <= i_cfg_wdata[7:0];
                wsp_pkg::CFG_PROP:   r_kp     <= i_cfg_wdata;
                wsp_pkg::CFG_INTEG:  r_ki     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && s_axis_tvalid) begin
            r_s0_left  <= s_axis_tdata[7:0];
            r_s0_right <= s_axis_tdata[15:8];
            r_s0_steer <= $signed(s_axis_tdata[24:16]);
        end
    end

    wsp_spike_filter u_left_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_en && r_s0_valid),
        .i_count (r_s0_left),
        .o_pick  (w_left_pick)
    );

    wsp_spike_filter u_right_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_en && r_s0_valid),
        .i_count (r_s0_right),
        .o_pick  (w_right_pick)
    );

    wsp_estimator u_estimator (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (r_s0_valid),
        .i_left_pick  (w_left_pick),
        .i_right_pick (w_right_pick),
        .i_steer      (r_s0_steer),
        .i_target     (r_target),
        .o_valid      (w_s1_valid),
        .o_word       (w_s1_word)
    );

    wsp_duty_stage u_duty (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_s1_valid),
        .i_word   (w_s1_word),
        .i_target (r_target),
        .i_kp     (r_kp),
        .i_ki     (r_ki),
        .o_valid  (w_out_valid),
        .o_left   (w_left_duty),
        .o_right  (w_right_duty),
        .o_speed  (w_speed)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {w_speed, w_right_duty, w_left_duty};

endmodule
